// ----- design/assert_macros.svh -----
// Assertion macros shared by the receiver RTL.
// Included by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante -> cons");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante => next cons");

`endif

// ----- design/sfr_pkg.sv -----
// Shared types and constants of the sensor frame receiver.
// No dependencies; imported by every module of the block.
package sfr_pkg;

  // Parameter default
  localparam int unsigned MaxPayloadDef = 12;

  // Configuration register reset values
  localparam logic [7:0]  HeaderByteRst   = 8'h16;
  localparam logic [15:0] TimeoutLimitRst = 16'd1000;

  // Register indexes on the APB port
  localparam logic RegHeaderByte   = 1'b0;
  localparam logic RegTimeoutLimit = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    StGood    = 2'd0,
    StCsum    = 2'd1,
    StTimeout = 2'd2,
    StLength  = 2'd3
  } status_e;

  // Parser phase, one-hot
  typedef enum logic [1:0] {
    PhIdle = 2'b01,
    PhRecv = 2'b10
  } phase_e;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [15:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  command;
    logic [15:0] co2_value;
  } result_t;

endpackage

// ----- design/sfr_apb_regs.sv -----
// APB configuration registers of the sensor frame receiver.
// Depends on sfr_pkg for register indexes, reset values and cfg_t.
module sfr_apb_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output sfr_pkg::cfg_t      cfg_o
);
  import sfr_pkg::*;

  logic [7:0]  header_q;
  logic [15:0] limit_q;
  logic        wr_en;

  // Write in the access phase; the port never stalls
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderByteRst;
      limit_q  <= TimeoutLimitRst;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegHeaderByte:   header_q <= pwdata[7:0];
        RegTimeoutLimit: limit_q  <= pwdata[15:0];
        default:         header_q <= header_q;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (paddr[2])
      RegHeaderByte:   prdata = {24'd0, header_q};
      RegTimeoutLimit: prdata = {16'd0, limit_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o.header_byte   = header_q;
  assign cfg_o.timeout_limit = limit_q;

endmodule

// ----- design/sfr_frame_fsm.sv -----
// Frame parser state and single-pass step logic of the sensor frame receiver.
// Depends on sfr_pkg for phase, status, cfg_t and result_t.
module sfr_frame_fsm #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MaxPayloadDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             func_i,
  input  logic [7:0]       rx_byte_i,
  input  sfr_pkg::cfg_t    cfg_i,
  output logic             res_vld_o,
  output sfr_pkg::result_t res_o
);
  import sfr_pkg::*;

  // Index runs up to MAX_PAYLOAD + 2 (the checksum byte)
  localparam int unsigned IdxW = $clog2(MAX_PAYLOAD + 3);

  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d, idx_inc;
  logic [7:0]      len_q, len_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      vhi_q, vhi_d;
  logic [7:0]      vlo_q, vlo_d;
  logic [15:0]     ticks_q, ticks_d, ticks_inc;
  logic [15:0]     last_q, last_d;
  logic [8:0]      csum_pos;
  logic            emit;
  status_e         emit_status;
  logic [7:0]      emit_cmd;

  assign idx_inc   = idx_q + IdxW'(1);
  assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
  assign csum_pos  = {1'b0, len_q} + 9'd2;

  // Step the parser for one beat
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    len_d       = len_q;
    sum_d       = sum_q;
    cmd_d       = cmd_q;
    vhi_d       = vhi_q;
    vlo_d       = vlo_q;
    ticks_d     = ticks_q;
    last_d      = last_q;
    emit        = 1'b0;
    emit_status = StGood;
    emit_cmd    = cmd_q;
    if (step_i) begin
      unique case (phase_q)
        PhIdle: begin
          // Wait for the header byte, drop everything else
          if (!func_i && (rx_byte_i == cfg_i.header_byte)) begin
            phase_d = PhRecv;
            idx_d   = '0;
            len_d   = 8'd0;
            sum_d   = rx_byte_i;
            cmd_d   = 8'd0;
            vhi_d   = 8'd0;
            vlo_d   = 8'd0;
            ticks_d = 16'd0;
          end
        end
        PhRecv: begin
          if (func_i) begin
            // Count ticks, abort once past the limit
            ticks_d = ticks_inc;
            if (ticks_inc > cfg_i.timeout_limit) begin
              emit        = 1'b1;
              emit_status = StTimeout;
            end
          end else begin
            idx_d = idx_inc;
            if (idx_inc == IdxW'(1)) begin
              // Length byte
              len_d = rx_byte_i;
              if (rx_byte_i > 8'(MAX_PAYLOAD)) begin
                emit        = 1'b1;
                emit_status = StLength;
                emit_cmd    = 8'd0;
              end else begin
                sum_d = sum_q + rx_byte_i;
              end
            end else if ({{(9-IdxW){1'b0}}, idx_inc} >= csum_pos) begin
              // Checksum byte closes the frame
              emit = 1'b1;
              if (rx_byte_i == (8'd0 - sum_q)) begin
                emit_status = StGood;
                last_d      = {vhi_q, vlo_q};
              end else begin
                emit_status = StCsum;
              end
            end else begin
              // Payload byte
              if (idx_inc == IdxW'(2)) begin
                cmd_d = rx_byte_i;
              end else if (idx_inc == IdxW'(3)) begin
                vhi_d = rx_byte_i;
              end else if (idx_inc == IdxW'(4)) begin
                vlo_d = rx_byte_i;
              end
              sum_d = sum_q + rx_byte_i;
            end
          end
        end
        default: phase_d = PhIdle;
      endcase
      // Return to idle after any result
      if (emit) begin
        phase_d = PhIdle;
        idx_d   = '0;
        ticks_d = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      idx_q   <= '0;
      len_q   <= 8'd0;
      sum_q   <= 8'd0;
      cmd_q   <= 8'd0;
      vhi_q   <= 8'd0;
      vlo_q   <= 8'd0;
      ticks_q <= 16'd0;
      last_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      cmd_q   <= cmd_d;
      vhi_q   <= vhi_d;
      vlo_q   <= vlo_d;
      ticks_q <= ticks_d;
      last_q  <= last_d;
    end
  end

  assign res_vld_o       = emit;
  assign res_o.status    = emit_status;
  assign res_o.command   = emit_cmd;
  assign res_o.co2_value = last_d;

endmodule

// ----- design/sensor_frame_receiver.sv -----
// Sensor frame receiver: parses length-prefixed UART frames with a sum checksum.
// Channels: in (func_i, rx_byte_i) carries one UART byte or one timer tick per
// beat; out (status_o, command_o, co2_value_o) carries one beat per finished or
// aborted frame. Both use valid/ready. Config sits on an APB port: header byte
// at address 0, timeout limit at address 4; write only while the block is idle.
// An input beat lands in an input register, is parsed by combinational logic and
// a result, if any, is loaded into the output register, from which it shows on
// out. One beat per cycle is taken in steady state while the output register
// is not stalled; the parser state update in the single step stage sets that.
// A stalled output register holds its beat and stalls the step stage; the input
// register then holds one more beat and in_ready_o drops.
// Reset clears the parser to idle, the latest CO2 value to zero and the config
// registers to header 0x16 and timeout 1000 ticks.
// Lengths above MAX_PAYLOAD abort the frame with a length status.
// Depends on sfr_pkg, sfr_apb_regs, sfr_frame_fsm and assert_macros.svh.
`include "assert_macros.svh"

module sensor_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  command_o,
  output logic [15:0] co2_value_o,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfr_pkg::*;

  cfg_t        cfg;
  result_t     res;
  logic        res_vld;
  logic        in_vld_q, in_vld_d;
  logic        func_q;
  logic [7:0]  byte_q;
  logic        out_vld_q, out_vld_d;
  result_t     out_q;
  logic        advance;
  logic        step;

  sfr_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Step stage moves when the output register is free or being drained
  assign advance    = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  assign in_vld_d = in_ready_o ? in_valid_i : in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      byte_q <= rx_byte_i;
    end
  end

  sfr_frame_fsm #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .func_i    (func_q),
    .rx_byte_i (byte_q),
    .cfg_i     (cfg),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Output register: load a result, hold while stalled
  assign out_vld_d = advance ? res_vld : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_q.status;
  assign command_o   = out_q.command;
  assign co2_value_o = out_q.co2_value;

  // Checks
  `ASSERT_IMPL(a_ready_drop_full, clk_i, rst_ni, !in_ready_o, in_vld_q && out_vld_q)
  `ASSERT_IMPL(a_result_needs_step, clk_i, rst_ni, res_vld, step)
  `ASSERT_IMPL(a_length_no_cmd, clk_i, rst_ni, out_valid_o && (status_o == StLength),
               command_o == 8'd0)
  `ASSERT_NEXT(a_result_loads, clk_i, rst_ni, res_vld, out_valid_o)

endmodule

// ----- dv/sfr_frame_checker.sv -----
// Result checker for the sensor frame receiver: snoops the input, output and
// APB ports, predicts each result beat and compares it field by field.
// Depends on sfr_pkg for the status and phase encodings and the result type.
module sfr_frame_checker #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel, as seen at the block
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  // Output channel, as seen at the block
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  command_i,
  input  logic [15:0] co2_value_i,
  // APB port, snooped for register writes
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import sfr_pkg::*;

  localparam int unsigned MaxReports = 10;

  // Shadow copy of the configuration registers
  logic [7:0]  hdr_q;
  logic [15:0] tmo_q;

  // Shadow parser state
  phase_e      phase_q;
  logic [7:0]  idx_q;
  logic [7:0]  len_q;
  logic [7:0]  sum_q;
  logic [7:0]  cmd_q;
  logic [7:0]  hi_q;
  logic [7:0]  lo_q;
  logic [15:0] ticks_q;
  logic [15:0] co2_q;

  // Results the block still owes, oldest first
  result_t     frame_results[$];
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%s", msg);
  endtask

  // Queue a result and drop back to idle
  task automatic close_frame(input status_e st, input logic [7:0] cmd);
    result_t r;
    r.status    = st;
    r.command   = cmd;
    r.co2_value = co2_q;
    frame_results.push_back(r);
    phase_q = PhIdle;
    idx_q   = '0;
    ticks_q = '0;
  endtask

  // Advance the shadow parser by one accepted input beat
  task automatic parse_beat(input logic is_tick, input logic [7:0] b);
    logic [7:0] csum;
    csum = 8'd0 - sum_q;
    if (phase_q == PhIdle) begin
      // Wait for the header; ignore ticks and other bytes
      if (!is_tick && b == hdr_q) begin
        phase_q = PhRecv;
        idx_q   = '0;
        len_q   = '0;
        sum_q   = b;
        cmd_q   = '0;
        hi_q    = '0;
        lo_q    = '0;
        ticks_q = '0;
      end
    end else if (is_tick) begin
      // Count ticks, saturating, and abort past the limit
      if (ticks_q != 16'hFFFF) ticks_q++;
      if (ticks_q > tmo_q) close_frame(StTimeout, cmd_q);
    end else begin
      idx_q++;
      if (idx_q == 8'd1) begin
        len_q = b;
        if (b > MAX_PAYLOAD) close_frame(StLength, 8'd0);
        else sum_q += b;
      end else if (idx_q >= len_q + 2) begin
        // Checksum byte closes the frame
        if (b == csum) begin
          co2_q = {hi_q, lo_q};
          close_frame(StGood, cmd_q);
        end else begin
          close_frame(StCsum, cmd_q);
        end
      end else begin
        case (idx_q)
          8'd2: cmd_q = b;
          8'd3: hi_q = b;
          8'd4: lo_q = b;
          default: ;
        endcase
        sum_q += b;
      end
    end
  endtask

  // Compare one output beat with the oldest prediction
  task automatic check_result();
    result_t want;
    if (frame_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result: status %0d command %02h co2 %04h",
                              status_i, command_i, co2_value_i));
    end else begin
      want = frame_results.pop_front();
      if (status_i !== want.status || command_i !== want.command ||
          co2_value_i !== want.co2_value) begin
        flag_mismatch($sformatf(
          "result mismatch: expected status %0d command %02h co2 %04h, got %0d %02h %04h",
          want.status, want.command, want.co2_value, status_i, command_i, co2_value_i));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q      = HeaderByteRst;
      tmo_q      = TimeoutLimitRst;
      phase_q    = PhIdle;
      idx_q      = '0;
      len_q      = '0;
      sum_q      = '0;
      cmd_q      = '0;
      hi_q       = '0;
      lo_q       = '0;
      ticks_q    = '0;
      co2_q      = '0;
      mismatches = 0;
      frame_results.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegHeaderByte) hdr_q = pwdata[7:0];
        else tmo_q = pwdata[15:0];
      end
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) parse_beat(func_i, rx_byte_i);
    end
    pending_o = frame_results.size();
  end

endmodule

// ----- dv/sensor_frame_receiver_tb.sv -----
// Testbench top for the sensor frame receiver: drives frames, ticks and noise
// under random backpressure and register settings, and gives the verdict.
// Depends on sfr_pkg, the receiver RTL and sfr_frame_checker.
module sensor_frame_receiver_tb;
  import sfr_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned MaxPayload   = MaxPayloadDef;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [7:0]  command_o;
  logic [15:0] co2_value_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_req;
  logic [7:0]  hdr_val;

  sensor_frame_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .command_o   (command_o),
    .co2_value_o (co2_value_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  sfr_frame_checker frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .func_i       (func_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .command_i    (command_o),
    .co2_value_i  (co2_value_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result sink: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic is_tick, input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= is_tick;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Send a frame with the current header, sprinkling ticks between bytes
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                            input logic [7:0] hi, input logic [7:0] lo,
                            input bit bad_sum, input int unsigned tick_pct);
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [7:0]  skew;
    int unsigned last;
    int unsigned i;
    last = (len > MaxPayload) ? 1 : len + 2;
    sum  = hdr_val;
    skew = 8'($urandom_range(255, 1));
    send_beat(1'b0, hdr_val);
    for (i = 1; i <= last; i++) begin
      if ($urandom_range(99) < tick_pct) send_beat(1'b1, 8'($urandom_range(255)));
      case (i)
        1: b = len;
        2: b = cmd;
        3: b = hi;
        4: b = lo;
        default: b = 8'($urandom_range(255));
      endcase
      if (i == len + 2) b = bad_sum ? (8'd0 - sum + skew) : (8'd0 - sum);
      send_beat(1'b0, b);
      sum += b;
    end
  endtask

  // Mostly well-formed frames, the rest noise and broken frames
  task automatic random_traffic(input int unsigned n_items, input int unsigned tick_pct);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      len  = 8'($urandom_range(MaxPayload));
      if (pick < 80) begin
        // one frame in eight carries a bad checksum
        send_frame(len, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), $urandom_range(7) == 0, tick_pct);
        sent += len + 3;
      end else if (pick < 86) begin
        send_frame(8'($urandom_range(255, MaxPayload + 1)), 8'd0, 8'd0, 8'd0, 1'b0,
                   tick_pct);
        sent += 2;
      end else if (pick < 93) begin
        send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        // truncated frame; later beats get absorbed into it
        send_beat(1'b0, hdr_val);
        repeat ($urandom_range(3)) send_beat(1'b0, 8'($urandom_range(255)));
        sent += 1;
      end
    end
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // APB write: setup beat, then access beat until pready
  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] hdr, input logic [15:0] tmo);
    hdr_val = hdr;
    write_reg(RegHeaderByte, {24'd0, hdr});
    write_reg(RegTimeoutLimit, {16'd0, tmo});
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = 1'b0;
    rx_byte_i    = 8'd0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_req     = 1'b0;
    hdr_val      = HeaderByteRst;
    snd_idle_pct = 29;
    rcv_idle_pct = 88;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: idle tick and noise, full, short and broken frames
    send_beat(1'b1, hdr_val);
    send_beat(1'b0, 8'h00);
    send_frame(8'd3, 8'hFF, 8'hFF, 8'hFF, 1'b0, 0);
    send_frame(8'd0, 8'h00, 8'h00, 8'h00, 1'b0, 0);
    send_frame(8'd2, 8'h5A, 8'h12, 8'h34, 1'b0, 0);
    send_frame(8'd1, 8'hA5, 8'h00, 8'h00, 1'b1, 0);
    send_frame(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 0);
    random_traffic(190, 10);

    // Lowest settings: any tick inside a frame aborts it
    wait_drained();
    set_config(8'h00, 16'd0);
    send_beat(1'b0, hdr_val);
    send_beat(1'b1, 8'hFF);
    send_beat(1'b0, hdr_val);
    send_beat(1'b0, 8'd3);
    send_beat(1'b0, 8'h77);
    send_beat(1'b1, 8'h00);
    random_traffic(100, 3);

    // Highest header, short timeout; swap the idling sides
    wait_drained();
    snd_idle_pct = 88;
    rcv_idle_pct = 29;
    set_config(8'hFF, 16'd5);
    random_traffic(190, 15);

    // No idling; the largest timeout keeps a ticking frame alive
    wait_drained();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_config(8'($urandom_range(255)), 16'hFFFF);
    send_beat(1'b0, hdr_val);
    send_beat(1'b0, 8'd0);
    repeat (20) send_beat(1'b1, 8'($urandom_range(255)));
    send_beat(1'b0, 8'd0 - hdr_val);

    // Hold the sink off while frames keep coming, to back up the block
    hold_req = 1'b1;
    repeat (8) send_frame(8'($urandom_range(4)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, 0);
    random_traffic(160, 20);

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/sfr_pkg.sv
design/sfr_apb_regs.sv
design/sfr_frame_fsm.sv
design/sensor_frame_receiver.sv
dv/sfr_frame_checker.sv
dv/sensor_frame_receiver_tb.sv
